FILE: rtl/pnrf_pkg.sv
// package for the packed nibble rectangle fill engine
// holds screen geometry, store widths, command codes and shared structs
// no dependencies
`default_nettype none

package pnrf_pkg;

    // screen geometry
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;
    localparam int ROW_BYTES     = (SCREEN_WIDTH + 1) / 2;
    localparam int BUF_BYTES     = ROW_BYTES * SCREEN_HEIGHT;
    localparam int STORE_DEPTH   = 2 * BUF_BYTES;
    localparam int SCAN_LINES    = 2 * SCREEN_HEIGHT;

    // derived widths
    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int COL_W   = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int ROW_W   = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam int LINE_W  = $clog2(SCAN_LINES);

    // field widths
    localparam int CMD_W   = 2;
    localparam int COORD_W = 11;
    localparam int SIZE_W  = 10;
    localparam int COLOR_W = 4;
    localparam int CALC_W  = 12;

    // scan result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_FILL  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_SWAP  = 2'd2,
        CMD_SCAN  = 2'd3
    } cmd_t;

    // one drawing command as seen by the engine
    typedef struct packed {
        cmd_t                       cmd;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic [SIZE_W-1:0]          rect_width;
        logic [SIZE_W-1:0]          rect_height;
        logic [COLOR_W-1:0]         color;
    } draw_cmd_t;

    // requests from the engine to the frame store
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
    } mem_req_t;

    // engine status towards the top level
    typedef struct packed {
        logic idle;
        logic wr_busy;
    } eng_status_t;

endpackage

`default_nettype wire

FILE: rtl/packed_nibble_rect_fill_engine_unit.sv
// Double-buffered 4-bit framebuffer (two pixels a byte, even x in the low nibble) with
// clipped rectangle fill, clear, swap and scan-out, all held in one single-port-write,
// single-port-read memory of 76800 bytes. After reset a clearing pass writes zero to
// every byte, one a cycle, while s_tready stays low. Per command: swap flips the
// buffer selection; scan returns one display byte a cycle sustained while the result
// queue has room, with up to four results queued behind m_tready; fill passes a set-up
// state, then does a read-modify-write of each touched byte through the memory ports,
// and the last write ends before the next command is taken; clear writes the 38400
// bytes of the draw buffer at one a cycle. A fill or clear stalls the input until it
// is done, and a new command is taken only with room left in the scan result queue.
// depends on pnrf_pkg, pnrf_store, pnrf_engine, pnrf_scan
`default_nettype none

module packed_nibble_rect_fill_engine_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // pos_x[10:0], pos_y[21:11], rect_width[31:22], rect_height[41:32],
    // color[45:42], zero fill[47:46]
    input  wire logic [47:0] s_tdata,
    // command[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // pixel_pair[7:0]
    output logic      [7:0]  m_tdata,
    // end_of_line
    output logic             m_tlast,
    // end_of_frame[0]
    output logic      [0:0]  m_tuser
);

    pnrf_pkg::draw_cmd_t    cmd;
    pnrf_pkg::mem_req_t     eng_req;
    pnrf_pkg::eng_status_t  eng_status;
    logic                   accept;
    logic                   draw_sel_reg;
    logic                   credit_ok;
    logic                   scan_req;
    logic                   scan_rd_en;
    logic [pnrf_pkg::ADDR_W-1:0] scan_rd_addr;
    logic                   mem_rd_en;
    logic [pnrf_pkg::ADDR_W-1:0] mem_rd_addr;
    logic [7:0]             mem_rd_data;

    // unpack the input beat
    assign cmd.cmd         = pnrf_pkg::cmd_t'(s_tuser);
    assign cmd.pos_x       = s_tdata[10:0];
    assign cmd.pos_y       = s_tdata[21:11];
    assign cmd.rect_width  = s_tdata[31:22];
    assign cmd.rect_height = s_tdata[41:32];
    assign cmd.color       = s_tdata[45:42];

    // input handshake
    assign s_tready = eng_status.idle && !eng_status.wr_busy && credit_ok;
    assign accept   = s_tvalid && s_tready;
    assign scan_req = accept && (cmd.cmd == pnrf_pkg::CMD_SCAN);

    // buffer selection
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_sel_reg <= 1'b0;
        end
        else if (accept && (cmd.cmd == pnrf_pkg::CMD_SWAP))
        begin
            draw_sel_reg <= ~draw_sel_reg;
        end
    end

    pnrf_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .cmd      (cmd),
        .draw_sel (draw_sel_reg),
        .rd_data  (mem_rd_data),
        .mem_req  (eng_req),
        .status   (eng_status)
    );

    pnrf_scan u_scan (
        .clk              (clk),
        .rst_n            (rst_n),
        .scan_req         (scan_req),
        .disp_sel         (~draw_sel_reg),
        .rd_data          (mem_rd_data),
        .rd_en            (scan_rd_en),
        .rd_addr          (scan_rd_addr),
        .credit_ok        (credit_ok),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_pixel_pair   (m_tdata),
        .out_end_of_line  (m_tlast),
        .out_end_of_frame (m_tuser[0])
    );

    // read port sharing: scans only start while the engine is idle
    assign mem_rd_en   = eng_req.rd_en || scan_rd_en;
    assign mem_rd_addr = eng_req.rd_en ? eng_req.rd_addr : scan_rd_addr;

    pnrf_store u_store (
        .clk     (clk),
        .wr_en   (eng_req.wr_en),
        .wr_addr (eng_req.wr_addr),
        .wr_data (eng_req.wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

`default_nettype wire

FILE: rtl/pnrf_store.sv
// frame store: both buffers in one synchronous memory
// one write port, one read port with registered read data; uses pnrf_pkg
`default_nettype none

module pnrf_store (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [pnrf_pkg::ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]                  wr_data,
    input  wire logic                        rd_en,
    input  wire logic [pnrf_pkg::ADDR_W-1:0] rd_addr,
    output logic      [7:0]                  rd_data
);

    logic [7:0] mem [pnrf_pkg::STORE_DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pnrf_engine.sv
// drawing engine: clipped rectangle read-modify-write, buffer clear and
// the clearing pass after reset; uses pnrf_pkg, drives pnrf_store
`default_nettype none

module pnrf_engine (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire pnrf_pkg::draw_cmd_t    cmd,
    input  wire logic                   draw_sel,
    input  wire logic [7:0]             rd_data,
    output pnrf_pkg::mem_req_t          mem_req,
    output pnrf_pkg::eng_status_t       status
);

    localparam int ADDR_W = pnrf_pkg::ADDR_W;
    localparam int COL_W  = pnrf_pkg::COL_W;
    localparam int ROW_W  = pnrf_pkg::ROW_W;
    localparam int CALC_W = pnrf_pkg::CALC_W;
    localparam int COLOR_W = pnrf_pkg::COLOR_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SETUP = 4'b0010,
        ST_FILL  = 4'b0100,
        ST_SWEEP = 4'b1000
    } state_t;

    state_t              state_reg, state_next;

    // rectangle walk
    logic [COL_W-1:0]    bc_reg, bc_next;
    logic [COL_W-1:0]    bc_first_reg, bc_first_next;
    logic [COL_W-1:0]    bc_last_reg, bc_last_next;
    logic                xa_odd_reg, xa_odd_next;
    logic                xl_odd_reg, xl_odd_next;
    logic [ROW_W-1:0]    y_reg, y_next;
    logic [ROW_W-1:0]    y_last_reg, y_last_next;
    logic [COLOR_W-1:0]  color_reg, color_next;
    logic                sel_reg, sel_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [ADDR_W-1:0]   row_addr_reg, row_addr_next;

    // write stage of the read-modify-write
    logic                wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0]   wr_addr_reg, wr_addr_next;
    logic                lo_en_reg, lo_en_next;
    logic                hi_en_reg, hi_en_next;

    // sweep for clear and reset
    logic [ADDR_W-1:0]   sweep_addr_reg, sweep_addr_next;
    logic [ADDR_W-1:0]   sweep_last_reg, sweep_last_next;
    logic [7:0]          sweep_data_reg, sweep_data_next;

    // clipping
    logic signed [CALC_W-1:0] x0, y0, xe, ye, xa, ya, xb, yb, xl, yl;
    logic                     rect_empty;
    logic [ADDR_W-1:0]        draw_base;
    logic                     lo_en_c, hi_en_c;

    always_comb
    begin
        x0 = CALC_W'(cmd.pos_x);
        y0 = CALC_W'(cmd.pos_y);
        xe = x0 + $signed({{(CALC_W-pnrf_pkg::SIZE_W){1'b0}}, cmd.rect_width});
        ye = y0 + $signed({{(CALC_W-pnrf_pkg::SIZE_W){1'b0}}, cmd.rect_height});
        xa = x0[CALC_W-1] ? '0 : x0;
        ya = y0[CALC_W-1] ? '0 : y0;
        xb = (xe > $signed(CALC_W'(pnrf_pkg::SCREEN_WIDTH)))
           ? $signed(CALC_W'(pnrf_pkg::SCREEN_WIDTH)) : xe;
        yb = (ye > $signed(CALC_W'(pnrf_pkg::SCREEN_HEIGHT)))
           ? $signed(CALC_W'(pnrf_pkg::SCREEN_HEIGHT)) : ye;
        xl = xb - CALC_W'(1);
        yl = yb - CALC_W'(1);
        rect_empty = (xb <= xa) || (yb <= ya);
    end

    assign draw_base = draw_sel ? ADDR_W'(pnrf_pkg::BUF_BYTES) : '0;

    // nibble enables of the current byte
    assign lo_en_c = !((bc_reg == bc_first_reg) && xa_odd_reg);
    assign hi_en_c = !((bc_reg == bc_last_reg) && !xl_odd_reg);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        bc_next         = bc_reg;
        bc_first_next   = bc_first_reg;
        bc_last_next    = bc_last_reg;
        xa_odd_next     = xa_odd_reg;
        xl_odd_next     = xl_odd_reg;
        y_next          = y_reg;
        y_last_next     = y_last_reg;
        color_next      = color_reg;
        sel_next        = sel_reg;
        addr_next       = addr_reg;
        row_addr_next   = row_addr_reg;
        wr_pend_next    = 1'b0;
        wr_addr_next    = wr_addr_reg;
        lo_en_next      = lo_en_reg;
        hi_en_next      = hi_en_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_last_next = sweep_last_reg;
        sweep_data_next = sweep_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (cmd.cmd == pnrf_pkg::CMD_FILL))
                begin
                    bc_first_next = xa[COL_W:1];
                    bc_last_next  = xl[COL_W:1];
                    xa_odd_next   = xa[0];
                    xl_odd_next   = xl[0];
                    y_next        = ya[ROW_W-1:0];
                    y_last_next   = yl[ROW_W-1:0];
                    color_next    = cmd.color;
                    sel_next      = draw_sel;
                    if (!rect_empty)
                    begin
                        state_next = ST_SETUP;
                    end
                end
                else if (start && (cmd.cmd == pnrf_pkg::CMD_CLEAR))
                begin
                    sweep_addr_next = draw_base;
                    sweep_last_next = draw_base + ADDR_W'(pnrf_pkg::BUF_BYTES - 1);
                    sweep_data_next = {cmd.color, cmd.color};
                    state_next      = ST_SWEEP;
                end
            end
            ST_SETUP:
            begin
                addr_next = (sel_reg ? ADDR_W'(pnrf_pkg::BUF_BYTES) : '0)
                          + ADDR_W'(ADDR_W'(y_reg) * ADDR_W'(pnrf_pkg::ROW_BYTES))
                          + ADDR_W'(bc_first_reg);
                row_addr_next = addr_next;
                bc_next       = bc_first_reg;
                state_next    = ST_FILL;
            end
            ST_FILL:
            begin
                wr_pend_next = 1'b1;
                wr_addr_next = addr_reg;
                lo_en_next   = lo_en_c;
                hi_en_next   = hi_en_c;
                if (bc_reg == bc_last_reg)
                begin
                    if (y_reg == y_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        y_next        = y_reg + ROW_W'(1);
                        bc_next       = bc_first_reg;
                        row_addr_next = row_addr_reg + ADDR_W'(pnrf_pkg::ROW_BYTES);
                        addr_next     = row_addr_next;
                    end
                end
                else
                begin
                    bc_next   = bc_reg + COL_W'(1);
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end
            ST_SWEEP:
            begin
                if (sweep_addr_reg == sweep_last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + ADDR_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers; reset starts the clearing pass over the whole store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            wr_pend_reg    <= 1'b0;
            sweep_addr_reg <= '0;
            sweep_last_reg <= ADDR_W'(pnrf_pkg::STORE_DEPTH - 1);
            sweep_data_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            wr_pend_reg    <= wr_pend_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_last_reg <= sweep_last_next;
            sweep_data_reg <= sweep_data_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        bc_reg       <= bc_next;
        bc_first_reg <= bc_first_next;
        bc_last_reg  <= bc_last_next;
        xa_odd_reg   <= xa_odd_next;
        xl_odd_reg   <= xl_odd_next;
        y_reg        <= y_next;
        y_last_reg   <= y_last_next;
        color_reg    <= color_next;
        sel_reg      <= sel_next;
        addr_reg     <= addr_next;
        row_addr_reg <= row_addr_next;
        wr_addr_reg  <= wr_addr_next;
        lo_en_reg    <= lo_en_next;
        hi_en_reg    <= hi_en_next;
    end

    // store requests: read in the walk, merge and write in the next cycle; sweep writes otherwise
    always_comb
    begin
        mem_req.rd_en   = (state_reg == ST_FILL);
        mem_req.rd_addr = addr_reg;
        if (wr_pend_reg)
        begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = wr_addr_reg;
            mem_req.wr_data = {hi_en_reg ? color_reg : rd_data[7:4],
                               lo_en_reg ? color_reg : rd_data[3:0]};
        end
        else
        begin
            mem_req.wr_en   = (state_reg == ST_SWEEP);
            mem_req.wr_addr = sweep_addr_reg;
            mem_req.wr_data = sweep_data_reg;
        end
    end

    assign status.idle    = (state_reg == ST_IDLE);
    assign status.wr_busy = wr_pend_reg;

endmodule

`default_nettype wire

FILE: rtl/pnrf_scan.sv
// scan-out: display position counters, store read and result queue
// uses pnrf_pkg; reads pnrf_store through the top level
`default_nettype none

module pnrf_scan (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        scan_req,
    input  wire logic                        disp_sel,
    input  wire logic [7:0]                  rd_data,
    output logic                             rd_en,
    output logic      [pnrf_pkg::ADDR_W-1:0] rd_addr,
    output logic                             credit_ok,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [7:0]                  out_pixel_pair,
    output logic                             out_end_of_line,
    output logic                             out_end_of_frame
);

    localparam int ADDR_W  = pnrf_pkg::ADDR_W;
    localparam int COL_W   = pnrf_pkg::COL_W;
    localparam int LINE_W  = pnrf_pkg::LINE_W;
    localparam int PTR_W   = pnrf_pkg::FIFO_PTR_W;
    localparam int CNT_W   = pnrf_pkg::FIFO_CNT_W;

    logic [LINE_W-1:0] line_reg, line_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] row_off_reg, row_off_next;
    logic              pend_reg;
    logic              pend_eol_reg, pend_eof_reg;
    logic [9:0]        fifo_mem [pnrf_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]  wptr_reg, rptr_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              eol, eof, push, pop;
    logic [CNT_W-1:0]  inflight;

    // position flags of the byte about to be read
    assign eol = (col_reg == COL_W'(pnrf_pkg::ROW_BYTES - 1));
    assign eof = eol && (line_reg == LINE_W'(pnrf_pkg::SCAN_LINES - 1));

    assign rd_en   = scan_req;
    assign rd_addr = (disp_sel ? ADDR_W'(pnrf_pkg::BUF_BYTES) : '0)
                   + row_off_reg + ADDR_W'(col_reg);

    // position advance; each stored row is sent on two lines
    always_comb
    begin
        line_next    = line_reg;
        col_next     = col_reg;
        row_off_next = row_off_reg;
        if (scan_req)
        begin
            if (eof)
            begin
                line_next    = '0;
                col_next     = '0;
                row_off_next = '0;
            end
            else if (eol)
            begin
                line_next = line_reg + LINE_W'(1);
                col_next  = '0;
                if (line_reg[0])
                begin
                    row_off_next = row_off_reg + ADDR_W'(pnrf_pkg::ROW_BYTES);
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // queue bookkeeping
    assign push      = pend_reg;
    assign pop       = out_valid && out_ready;
    assign inflight  = count_reg + CNT_W'(pend_reg);
    assign credit_ok = (inflight < CNT_W'(pnrf_pkg::FIFO_DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg    <= '0;
            col_reg     <= '0;
            row_off_reg <= '0;
            pend_reg    <= 1'b0;
            wptr_reg    <= '0;
            rptr_reg    <= '0;
            count_reg   <= '0;
        end
        else
        begin
            line_reg    <= line_next;
            col_reg     <= col_next;
            row_off_reg <= row_off_next;
            pend_reg    <= scan_req;
            count_reg   <= count_next;
            if (push)
            begin
                wptr_reg <= wptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + PTR_W'(1);
            end
        end
    end

    // flags travel beside the read, data joins them in the queue
    always_ff @(posedge clk)
    begin
        if (scan_req)
        begin
            pend_eol_reg <= eol;
            pend_eof_reg <= eof;
        end
        if (push)
        begin
            fifo_mem[wptr_reg] <= {pend_eof_reg, pend_eol_reg, rd_data};
        end
    end

    assign out_valid        = (count_reg != '0);
    assign out_pixel_pair   = fifo_mem[rptr_reg][7:0];
    assign out_end_of_line  = fifo_mem[rptr_reg][8];
    assign out_end_of_frame = fifo_mem[rptr_reg][9];

endmodule

`default_nettype wire

FILE: rtl/pnrf_checker.sv
// port-level checker for the packed nibble rectangle fill engine
// depends on pnrf_pkg; bound to packed_nibble_rect_fill_engine_unit
`default_nettype none

module pnrf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tlast,
    input wire logic [0:0]  m_tuser
);

    logic [2:0] outstanding_reg;
    logic       scan_in, beat_out;

    assign scan_in  = s_tvalid && s_tready && (s_tuser == pnrf_pkg::CMD_SCAN);
    assign beat_out = m_tvalid && m_tready;

    // scans accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_reg + 3'(scan_in) - 3'(beat_out);
        end
    end

    // no result beat without an accepted scan behind it
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (outstanding_reg != 3'd0))
        else $error("result beat without a pending scan");

    // results in flight never exceed the queue
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= 3'd4)
        else $error("too many scans in flight");

    // end of frame only on the last byte of a line
    a_eof_eol: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("end of frame without end of line");

    // a stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)
                                     && $stable(m_tlast) && $stable(m_tuser)))
        else $error("stalled result beat changed");

endmodule

bind packed_nibble_rect_fill_engine_unit pnrf_checker u_pnrf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: test/packed_nibble_rect_fill_engine_unit_tb.sv
// testbench for packed_nibble_rect_fill_engine_unit: fill, clear, swap and scan commands
// checked against a shadow copy of both frame buffers and the scan position
// depends on pnrf_pkg and the rtl of the block
`timescale 1ns / 100ps

module packed_nibble_rect_fill_engine_unit_tb;

    import pnrf_pkg::*;

    localparam int RANDOM_ITEMS   = 1600;
    localparam int CALM_ITEMS     = 200;
    localparam int CLEAR_BUDGET   = 6;
    localparam int LARGE_BUDGET   = 30;
    localparam int SETTLE_CYCLES  = 20;

    // one expected scan beat
    typedef struct {
        logic [7:0] pair;
        logic       eol;
        logic       eof;
    } scan_beat_t;

    // shadow of both buffers, the swap bit and the scan position
    class nibble_frame_shadow;
        bit [7:0]   store_bytes [STORE_DEPTH];
        bit         draw_sel;
        int         scan_line;
        int         scan_col;
        scan_beat_t pending_pairs [$];
        int         mismatches;

        function void take_command(draw_cmd_t c);
            int         base;
            int         x0;
            int         y0;
            int         xa;
            int         ya;
            int         xb;
            int         yb;
            int         px;
            int         py;
            int         idx;
            scan_beat_t beat;
            base = draw_sel ? BUF_BYTES : 0;
            case (c.cmd)
                CMD_FILL:
                begin
                    // clip the rectangle to the screen, then write nibble by nibble
                    x0 = $signed(c.pos_x);
                    y0 = $signed(c.pos_y);
                    xa = (x0 < 0) ? 0 : x0;
                    ya = (y0 < 0) ? 0 : y0;
                    xb = x0 + int'(c.rect_width);
                    yb = y0 + int'(c.rect_height);
                    if (xb > SCREEN_WIDTH)
                        xb = SCREEN_WIDTH;
                    if (yb > SCREEN_HEIGHT)
                        yb = SCREEN_HEIGHT;
                    for (py = ya; py < yb; py++)
                    begin
                        for (px = xa; px < xb; px++)
                        begin
                            idx = base + py * ROW_BYTES + (px >> 1);
                            if (px[0])
                                store_bytes[idx][7:4] = c.color;
                            else
                                store_bytes[idx][3:0] = c.color;
                        end
                    end
                end
                CMD_CLEAR:
                begin
                    for (idx = 0; idx < BUF_BYTES; idx++)
                        store_bytes[base + idx] = {c.color, c.color};
                end
                CMD_SWAP:
                begin
                    draw_sel = ~draw_sel;
                end
                CMD_SCAN:
                begin
                    // each stored row goes out on two scan lines
                    idx = (draw_sel ? 0 : BUF_BYTES) + (scan_line >> 1) * ROW_BYTES + scan_col;
                    beat.pair = store_bytes[idx];
                    beat.eol = (scan_col == ROW_BYTES - 1);
                    beat.eof = beat.eol && (scan_line == SCAN_LINES - 1);
                    pending_pairs.push_back(beat);
                    if (beat.eol)
                    begin
                        scan_col = 0;
                        scan_line = beat.eof ? 0 : scan_line + 1;
                    end
                    else
                    begin
                        scan_col++;
                    end
                end
            endcase
        endfunction

        function void take_pixel_pair(logic [7:0] pair, logic eol, logic eof);
            scan_beat_t want;
            if (pending_pairs.size() == 0)
            begin
                $display("%0t ns: scan beat with none expected, actual pair %h eol %b eof %b",
                         $time, pair, eol, eof);
                mismatches++;
                return;
            end
            want = pending_pairs.pop_front();
            if (pair !== want.pair)
            begin
                $display("%0t ns: pixel pair mismatch, expected %h actual %h",
                         $time, want.pair, pair);
                mismatches++;
            end
            if (eol !== want.eol)
            begin
                $display("%0t ns: end of line mismatch, expected %b actual %b",
                         $time, want.eol, eol);
                mismatches++;
            end
            if (eof !== want.eof)
            begin
                $display("%0t ns: end of frame mismatch, expected %b actual %b",
                         $time, want.eof, eof);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    bit calm_run = 1'b0;
    int clears_done = 0;
    int large_done = 0;
    int send_steady = 0;

    nibble_frame_shadow frame_shadow = new();

    packed_nibble_rect_fill_engine_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // fail safe well beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // scan beats are checked on the rising edge
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready)
            frame_shadow.take_pixel_pair(m_tdata, m_tlast, m_tuser[0]);
    end

    // sink side backpressure in bursts, with steady stretches
    initial
    begin : sink_side
        int hold;
        int steady;
        hold = 0;
        steady = 0;
        forever
        begin
            @(negedge clk);
            if (calm_run || steady > 0)
            begin
                m_tready = 1'b1;
                if (steady > 0)
                    steady--;
            end
            else if (hold > 0)
            begin
                m_tready = 1'b0;
                hold--;
            end
            else if ($urandom_range(0, 59) == 0)
            begin
                m_tready = 1'b1;
                steady = $urandom_range(20, 200);
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                m_tready = 1'b0;
                hold = $urandom_range(0, 12);
            end
            else
            begin
                m_tready = 1'b1;
            end
        end
    end

    function automatic draw_cmd_t make_cmd(cmd_t k, int x, int y, int w, int h, int col);
        draw_cmd_t c;
        c.cmd = k;
        c.pos_x = x[10:0];
        c.pos_y = y[10:0];
        c.rect_width = w[9:0];
        c.rect_height = h[9:0];
        c.color = col[3:0];
        return c;
    endfunction

    // rectangle mostly near the screen and small, now and then anywhere and any size
    function automatic draw_cmd_t random_fill(bit allow_large);
        draw_cmd_t c;
        c = draw_cmd_t'({$urandom, $urandom});
        c.cmd = CMD_FILL;
        if ($urandom_range(0, 9) < 7)
            c.pos_x = 11'($urandom_range(0, 359) - 20);
        if ($urandom_range(0, 9) < 7)
            c.pos_y = 11'($urandom_range(0, 279) - 20);
        if (allow_large && large_done < LARGE_BUDGET && $urandom_range(0, 29) == 0)
        begin
            large_done++;
        end
        else
        begin
            c.rect_width = 10'($urandom_range(0, 15));
            c.rect_height = 10'($urandom_range(0, 15));
        end
        return c;
    endfunction

    // command mix for the random part, unused fields left random
    function automatic draw_cmd_t random_command();
        draw_cmd_t c;
        int        r;
        c = draw_cmd_t'({$urandom, $urandom});
        r = $urandom_range(0, 199);
        if (r == 0 && clears_done < CLEAR_BUDGET)
        begin
            clears_done++;
            c.cmd = CMD_CLEAR;
        end
        else if (r >= 1 && r < 20)
        begin
            c.cmd = CMD_SWAP;
        end
        else if (r >= 20 && r < 110)
        begin
            c.cmd = CMD_SCAN;
        end
        else
        begin
            c = random_fill(1'b1);
        end
        return c;
    endfunction

    // present one command beat and hold it until taken
    task automatic issue(input draw_cmd_t c);
        s_tuser = c.cmd;
        s_tdata = {2'b00, c.color, c.rect_height, c.rect_width, c.pos_y, c.pos_x};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        frame_shadow.take_command(c);
        @(negedge clk);
    endtask

    // random source side gap after a beat
    task automatic sender_gap();
        int n;
        if (calm_run)
            return;
        if (send_steady > 0)
        begin
            send_steady--;
        end
        else if ($urandom_range(0, 49) == 0)
        begin
            send_steady = $urandom_range(20, 150);
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            n = $urandom_range(1, 13);
            repeat (n) @(negedge clk);
        end
    endtask

    initial
    begin : source_side
        draw_cmd_t  directed [$];
        draw_cmd_t  c;
        int         n;

        // the block clears its store after reset with s_tready low
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, clipping, zero sizes, both nibbles, all commands
        directed.push_back(make_cmd(CMD_FILL, -1024, -1024, 1023, 1023, 15));
        directed.push_back(make_cmd(CMD_FILL, 1023, 5, 1023, 1023, 3));
        directed.push_back(make_cmd(CMD_FILL, 10, 10, 0, 20, 7));
        directed.push_back(make_cmd(CMD_FILL, 10, 10, 20, 0, 7));
        directed.push_back(make_cmd(CMD_FILL, 0, 0, 1, 1, 1));
        directed.push_back(make_cmd(CMD_FILL, 1, 0, 1, 1, 2));
        directed.push_back(make_cmd(CMD_FILL, 319, 239, 1, 1, 5));
        directed.push_back(make_cmd(CMD_FILL, -3, -2, 6, 4, 9));
        directed.push_back(make_cmd(CMD_FILL, 316, 236, 10, 10, 12));
        directed.push_back(make_cmd(CMD_SWAP, 0, 0, 0, 0, 0));
        repeat (4) directed.push_back(make_cmd(CMD_SCAN, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 10));
        directed.push_back(make_cmd(CMD_FILL, 2, 0, 3, 1, 0));
        directed.push_back(make_cmd(CMD_SWAP, -1, -1, 1023, 1023, 15));
        repeat (4) directed.push_back(make_cmd(CMD_SCAN, -1, -1, 1023, 1023, 15));
        directed.push_back(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(CMD_SWAP, 0, 0, 0, 0, 0));
        directed.push_back(make_cmd(CMD_SCAN, 0, 0, 0, 0, 0));
        foreach (directed[i])
        begin
            issue(directed[i]);
            sender_gap();
        end

        // random mix, with one full drain of the scan beats half way
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
            begin
                s_tvalid = 1'b0;
                while (frame_shadow.pending_pairs.size() != 0)
                    @(negedge clk);
            end
            c = random_command();
            issue(c);
            sender_gap();
        end

        // no idling from here: back to back scans with a fill and a swap between them
        calm_run = 1'b1;
        for (n = 0; n < CALM_ITEMS; n++)
        begin
            if (n == CALM_ITEMS / 2)
                issue(make_cmd(CMD_SWAP, 0, 0, 0, 0, 0));
            if (n == CALM_ITEMS / 4)
                issue(random_fill(1'b0));
            issue(make_cmd(CMD_SCAN, 0, 0, 0, 0, 0));
        end
        s_tvalid = 1'b0;

        // wait for the last beats, then a short settle
        while (frame_shadow.pending_pairs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (frame_shadow.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
